// ----- hdl/velocity_command_slew_limiter_top_assert.svh -----
// Assertion macros for the velocity command slew limiter.
// Each macro checks on the rising edge of clock and is disabled while reset is high.
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_TOP_ASSERT_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_TOP_ASSERT_SVH

`ifndef SYNTH

// The condition must hold in the cycle after the trigger.
`define VCSL_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// The condition must hold in the same cycle as the trigger.
`define VCSL_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

`else

`define VCSL_ASSERT_NEXT(label, trig, cond, msg)
`define VCSL_ASSERT_NOW(label, trig, cond, msg)

`endif

`endif

// ----- hdl/vcsl_pkg.sv -----
package vcsl_pkg;

   // Field widths.
   localparam int NUM_AXES = 3;
   localparam int VEL_W    = 32;
   localparam int LIM_W    = 31;
   localparam int TIME_W   = 32;
   localparam int DT_W     = 20;
   localparam int STEP_W   = 32;

   // Packed stream payloads.
   localparam int REQ_DATA_W = TIME_W + NUM_AXES * VEL_W;
   localparam int RSP_DATA_W = 2 * NUM_AXES * VEL_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_VEL_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VEL_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VEL_YAW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ACCEL_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ACCEL_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ACCEL_YAW = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DT        = 3'd7;

   // Register reset values.
   localparam logic [LIM_W-1:0]  MAX_VEL_RESET   = 31'd65536;
   localparam logic [LIM_W-1:0]  MAX_ACCEL_RESET = 31'd6554;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET   = 32'd100000;
   localparam logic [DT_W-1:0]   MAX_DT_RESET    = 20'd10000;

   // Item kinds.
   localparam logic ACT_COMMAND = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   // Step divider: floor(accel * dt / 1e6) is taken as a shift by 6 followed by
   // a long division by 15625 in 18-bit digits, each digit found with a
   // reciprocal multiply and one correction.
   localparam int PROD_W      = LIM_W + DT_W;
   localparam int PRE_SHIFT   = 6;
   localparam int STEP_DIV    = 15625;
   localparam int DIV_REM_W   = 14;
   localparam int SLACK_W     = DIV_REM_W + 1;
   localparam int CHUNK_W     = 18;
   localparam int NUM_CHUNKS  = 3;
   localparam int WIDE_W      = CHUNK_W * NUM_CHUNKS;
   localparam int NUM_W       = DIV_REM_W + CHUNK_W;
   localparam int RECIP_SHIFT = NUM_W;
   localparam int RECIP_W     = 19;
   localparam int MUL_W       = NUM_W + RECIP_W;
   localparam int QD_W        = CHUNK_W + DIV_REM_W;
   localparam logic [RECIP_W-1:0] STEP_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / STEP_DIV);

   // One load enable for the product stage and two for each digit.
   localparam int STEP_LD_W = 1 + 2 * NUM_CHUNKS;

   // Accepted request item.
   typedef struct packed {
      logic                               action;
      logic [TIME_W-1:0]                  time_us;
      logic [NUM_AXES-1:0][VEL_W-1:0]     target;
   } req_item_type;

   // What an item carries down the pipeline next to the step divider.
   typedef struct packed {
      logic                               action;
      logic                               stale;
      logic [NUM_AXES-1:0][VEL_W-1:0]     goal;
   } side_type;

endpackage

// ----- hdl/vcsl_step.sv -----
module vcsl_step (
   input  logic                              clock,
   input  logic [vcsl_pkg::STEP_LD_W-1:0]    load,
   input  logic [vcsl_pkg::LIM_W-1:0]        accel,
   input  logic [vcsl_pkg::DT_W-1:0]         dt,
   output logic [vcsl_pkg::STEP_W-1:0]       step
);
   import vcsl_pkg::*;

   logic [PROD_W-1:0]                          prod_ff;
   logic [WIDE_W-1:0]                          dividend;
   logic [NUM_CHUNKS-1:0][WIDE_W-1:0]          div_src;
   logic [NUM_CHUNKS-2:0][WIDE_W-1:0]          div_m_ff;
   logic [NUM_CHUNKS-2:0][WIDE_W-1:0]          div_q_ff;
   logic [NUM_CHUNKS-1:0][DIV_REM_W-1:0]       rem_prev;
   logic [NUM_CHUNKS-1:0][DIV_REM_W-1:0]       rem_ff;
   logic [NUM_CHUNKS-1:0][NUM_W-1:0]           num_ff;
   logic [NUM_CHUNKS-1:0][MUL_W-1:0]           mul_ff;
   logic [NUM_CHUNKS-1:0][WIDE_W-1:0]          quo_prev;
   logic [NUM_CHUNKS-1:1][WIDE_W-1:0]          quo_m_ff;
   logic [NUM_CHUNKS-1:0][WIDE_W-1:0]          quo_ff;

   // Full product of the acceleration limit and the capped interval.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff <= PROD_W'(accel) * PROD_W'(dt);
      end
   end

   // The low six bits only ever feed the remainder, so they are dropped here.
   assign dividend = WIDE_W'(prod_ff[PROD_W-1:PRE_SHIFT]);

   genvar k;
   for (k = 0; k < NUM_CHUNKS; k++) begin : g_digit
      logic [NUM_W-1:0]     num;
      logic [CHUNK_W-1:0]   q_est;
      logic [CHUNK_W-1:0]   q_digit;
      logic [QD_W-1:0]      q_times_d;
      logic [SLACK_W-1:0]   rem_raw;
      logic                 over;

      // Each digit takes the dividend, remainder and quotient so far from the
      // stage in front of it, so every item keeps its own values.
      if (k == 0) begin : g_first
         assign rem_prev[k] = '0;
         assign div_src[k]  = dividend;
         assign quo_prev[k] = '0;
      end else begin : g_next
         assign rem_prev[k] = rem_ff[k-1];
         assign div_src[k]  = div_q_ff[k-1];
         assign quo_prev[k] = quo_m_ff[k];

         always_ff @(posedge clock) begin
            if (load[1+2*k]) begin
               quo_m_ff[k] <= quo_ff[k-1];
            end
         end
      end

      // The dividend travels on with the item while later digits need it.
      if (k < NUM_CHUNKS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (load[1+2*k]) begin
               div_m_ff[k] <= div_src[k];
            end
         end

         always_ff @(posedge clock) begin
            if (load[2+2*k]) begin
               div_q_ff[k] <= div_m_ff[k];
            end
         end
      end

      // Partial dividend: previous remainder followed by the next digit.
      assign num = {rem_prev[k], div_src[k][WIDE_W-1-k*CHUNK_W -: CHUNK_W]};

      // Reciprocal multiply gives the quotient digit or one less.
      always_ff @(posedge clock) begin
         if (load[1+2*k]) begin
            num_ff[k] <= num;
            mul_ff[k] <= MUL_W'(num) * MUL_W'(STEP_RECIP);
         end
      end

      // The true remainder is below twice the divisor, so narrow arithmetic
      // is exact; one compare and subtract fixes the digit.
      assign q_est     = mul_ff[k][RECIP_SHIFT +: CHUNK_W];
      assign q_times_d = QD_W'(q_est) * QD_W'(STEP_DIV);
      assign rem_raw   = num_ff[k][SLACK_W-1:0] - q_times_d[SLACK_W-1:0];
      assign over      = (rem_raw >= SLACK_W'(STEP_DIV));
      assign q_digit   = q_est + CHUNK_W'(over);

      always_ff @(posedge clock) begin
         if (load[2+2*k]) begin
            quo_ff[k] <= {quo_prev[k][WIDE_W-CHUNK_W-1:0], q_digit};
            rem_ff[k] <= over ? DIV_REM_W'(rem_raw - SLACK_W'(STEP_DIV))
                              : rem_raw[DIV_REM_W-1:0];
         end
      end
   end

   // The last digit stage holds the whole quotient.
   assign step = STEP_W'(quo_ff[NUM_CHUNKS-1]);

endmodule

// ----- hdl/velocity_command_slew_limiter_top.sv -----
// Three-axis velocity setpoint slew limiter (x, y, yaw), signed Q16.16.
// Request stream: tuser is the item kind (0 command, 1 control tick); tdata
// holds the time stamp and three targets. A command clamps and stores the
// targets as goals; a tick moves each ramp toward its goal by at most
// floor(max_accel * dT / 1e6), or zeroes the ramps when the last command is
// older than the timeout. Every request gives exactly one response carrying
// the ramps, the goals and a timed-out flag in tuser.
// Configuration is written through csr_we / csr_index / csr_wdata; the user
// must write it only while the block is idle (the block does not enforce
// this). An index names the register in the order x, y, yaw velocity limits,
// x, y, yaw acceleration limits, timeout, interval cap. Throughput: one item
// per cycle unless the receiver stalls, set by a ten-register pipeline whose
// depth comes from the digit-by-digit step divider (two registers per digit).
// Reset clears the pipeline, the goals, ramps and time stamps to zero and
// loads the register defaults. When the receiver stalls, the pipeline closes
// its gaps and req_tready falls once all ten registers hold items.
`include "velocity_command_slew_limiter_top_assert.svh"

module velocity_command_slew_limiter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // time_us, target_x, target_y, target_yaw
   input  logic [vcsl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // ramp_x, ramp_y, ramp_yaw, clamped_x, clamped_y, clamped_yaw
   output logic [vcsl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // timed_out
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [vcsl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vcsl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vcsl_pkg::*;

   localparam int NumStages = 2 + STEP_LD_W;

   // Configuration registers.
   logic [NUM_AXES-1:0][LIM_W-1:0]   max_vel_ff, max_vel_in;
   logic [NUM_AXES-1:0][LIM_W-1:0]   max_accel_ff, max_accel_in;
   logic [TIME_W-1:0]                timeout_ff, timeout_in;
   logic [DT_W-1:0]                  max_dt_ff, max_dt_in;

   // Pipeline control.
   logic [NumStages-1:0]             valid_ff, valid_in;
   logic [NumStages:0]               adv;
   logic                             req_xfer;
   logic                             first_move;
   logic                             out_load;

   // Pipeline payload.
   req_item_type                     req_in, req_ff;
   side_type                         side_in;
   side_type                         side_ff [1:NumStages-1];
   side_type                         side_out;
   logic [DT_W-1:0]                  dt_in, dt_ff;
   logic [TIME_W-1:0]                tick_gap, cmd_age;
   logic [NUM_AXES-1:0][STEP_W-1:0]  step;

   // Block state; the goals, ramps and flag are also the response register.
   logic [NUM_AXES-1:0][VEL_W-1:0]   goal_ff, goal_in;
   logic [NUM_AXES-1:0][VEL_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]                last_tick_ff, last_tick_in;
   logic [TIME_W-1:0]                cmd_time_ff, cmd_time_in;
   logic                             timed_out_ff, timed_out_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic signed [VEL_W-1:0]          vel_lim [NUM_AXES];
   logic signed [VEL_W+1:0]          diff [NUM_AXES];
   logic signed [VEL_W+1:0]          step_s [NUM_AXES];

   // Register writes.
   always_comb begin
      max_vel_in   = max_vel_ff;
      max_accel_in = max_accel_ff;
      timeout_in   = timeout_ff;
      max_dt_in    = max_dt_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_VEL_X:     max_vel_in[0]   = csr_wdata[LIM_W-1:0];
            REG_MAX_VEL_Y:     max_vel_in[1]   = csr_wdata[LIM_W-1:0];
            REG_MAX_VEL_YAW:   max_vel_in[2]   = csr_wdata[LIM_W-1:0];
            REG_MAX_ACCEL_X:   max_accel_in[0] = csr_wdata[LIM_W-1:0];
            REG_MAX_ACCEL_Y:   max_accel_in[1] = csr_wdata[LIM_W-1:0];
            REG_MAX_ACCEL_YAW: max_accel_in[2] = csr_wdata[LIM_W-1:0];
            REG_TIMEOUT:       timeout_in      = csr_wdata[TIME_W-1:0];
            REG_MAX_DT:        max_dt_in       = csr_wdata[DT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            max_vel_ff[a]   <= MAX_VEL_RESET;
            max_accel_ff[a] <= MAX_ACCEL_RESET;
         end
         timeout_ff <= TIMEOUT_RESET;
         max_dt_ff  <= MAX_DT_RESET;
      end else begin
         max_vel_ff   <= max_vel_in;
         max_accel_ff <= max_accel_in;
         timeout_ff   <= timeout_in;
         max_dt_ff    <= max_dt_in;
      end
   end

   // A stage may take a new item when it is empty or its item moves on.
   always_comb begin
      adv[NumStages] = !rsp_valid_ff || rsp_tready;
      for (int i = NumStages - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];
   assign req_xfer   = req_tvalid && adv[0];
   assign first_move = adv[1] && valid_ff[0];
   assign out_load   = adv[NumStages] && valid_ff[NumStages-1];

   always_comb begin
      valid_in[0] = adv[0] ? req_xfer : valid_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
      rsp_valid_in = adv[NumStages] ? valid_ff[NumStages-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_comb begin
      req_in.action  = req_tuser;
      req_in.time_us = req_tdata[TIME_W-1:0];
      for (int a = 0; a < NUM_AXES; a++) begin
         req_in.target[a] = req_tdata[TIME_W + a*VEL_W +: VEL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         req_ff <= req_in;
      end
   end

   // First stage: tick interval, command age and target clamping.
   assign tick_gap = req_ff.time_us - last_tick_ff;
   assign cmd_age  = req_ff.time_us - cmd_time_ff;
   assign dt_in    = (tick_gap > TIME_W'(max_dt_ff)) ? max_dt_ff : tick_gap[DT_W-1:0];

   always_comb begin
      side_in.action = req_ff.action;
      side_in.stale  = (req_ff.action == ACT_TICK) && (cmd_age > timeout_ff);
      for (int a = 0; a < NUM_AXES; a++) begin
         vel_lim[a] = signed'({1'b0, max_vel_ff[a]});
         if (signed'(req_ff.target[a]) > vel_lim[a]) begin
            side_in.goal[a] = vel_lim[a];
         end else if (signed'(req_ff.target[a]) < -vel_lim[a]) begin
            side_in.goal[a] = -vel_lim[a];
         end else begin
            side_in.goal[a] = req_ff.target[a];
         end
      end
   end

   // Time stamps follow items in order as they leave the input register.
   always_comb begin
      last_tick_in = last_tick_ff;
      cmd_time_in  = cmd_time_ff;
      if (first_move) begin
         if (req_ff.action == ACT_TICK) begin
            last_tick_in = req_ff.time_us;
         end else begin
            cmd_time_in = req_ff.time_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         side_ff[1] <= side_in;
         dt_ff      <= dt_in;
      end
      for (int k = 2; k < NumStages; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // One step divider per axis runs alongside the side pipeline.
   genvar g;
   for (g = 0; g < NUM_AXES; g++) begin : g_axis
      vcsl_step u_step (
         .clock (clock),
         .load  (adv[NumStages-1:2]),
         .accel (max_accel_ff[g]),
         .dt    (dt_ff),
         .step  (step[g])
      );
   end

   // Last stage: apply the item to the goals and ramps.
   assign side_out = side_ff[NumStages-1];

   always_comb begin
      goal_in      = goal_ff;
      now_in       = now_ff;
      timed_out_in = timed_out_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         diff[a]   = (VEL_W+2)'(signed'(goal_ff[a])) - (VEL_W+2)'(signed'(now_ff[a]));
         step_s[a] = signed'({2'b00, step[a]});
      end
      if (out_load) begin
         timed_out_in = side_out.stale;
         if (side_out.action == ACT_COMMAND) begin
            goal_in = side_out.goal;
         end else if (side_out.stale) begin
            now_in = '0;
         end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
               // A ramp never passes its goal, so the 32-bit sums cannot wrap.
               if (diff[a] > step_s[a]) begin
                  now_in[a] = now_ff[a] + step[a];
               end else if (diff[a] < -step_s[a]) begin
                  now_in[a] = now_ff[a] - step[a];
               end else begin
                  now_in[a] = goal_ff[a];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff      <= '0;
         now_ff       <= '0;
         last_tick_ff <= '0;
         cmd_time_ff  <= '0;
         timed_out_ff <= 1'b0;
      end else begin
         goal_ff      <= goal_in;
         now_ff       <= now_in;
         last_tick_ff <= last_tick_in;
         cmd_time_ff  <= cmd_time_in;
         timed_out_ff <= timed_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {goal_ff, now_ff};
   assign rsp_tuser  = timed_out_ff;

   // Checks on the state update.
   `VCSL_ASSERT_NEXT(a_state_hold, !out_load, $stable(now_ff) && $stable(goal_ff), "state moved without a result")
   `VCSL_ASSERT_NEXT(a_cmd_fresh, out_load && (side_out.action == ACT_COMMAND), !rsp_tuser, "command result flagged stale")
   `VCSL_ASSERT_NOW(a_stale_zero, rsp_tvalid && rsp_tuser, now_ff == '0, "stale result with nonzero ramps")

endmodule

// ----- dv/velocity_command_slew_limiter_top_tb.sv -----
`default_nettype none

module velocity_command_slew_limiter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vcsl_pkg::*;

   localparam int          CLK_PERIOD    = 10;
   localparam int          RESET_CYCLES  = 12;
   localparam int          PIPE_LATENCY  = 9;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          NUM_REGS      = 8;
   localparam int          NUM_PHASES    = 7;
   localparam int          PHASE_ITEMS   = 205;
   localparam int          DIRECTED_ROWS = 18;
   localparam longint unsigned USEC_PER_SEC = 64'd1000000;

   // One response: ramps and goals with x in the lowest slot.
   typedef struct packed {
      logic [NUM_AXES-1:0][VEL_W-1:0] ramp;
      logic [NUM_AXES-1:0][VEL_W-1:0] goal;
      logic                           timed_out;
   } setpoint_type;

   // One row of the directed table. Axis triples are written yaw, y, x.
   typedef struct packed {
      logic                           act;
      logic [TIME_W-1:0]              t;
      logic [NUM_AXES-1:0][VEL_W-1:0] target;
      logic                           typed;
      setpoint_type                   want;
   } stim_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   velocity_command_slew_limiter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mirror of the limit registers and of the ramp state.
   logic [NUM_AXES-1:0][LIM_W-1:0] vel_lim;
   logic [NUM_AXES-1:0][LIM_W-1:0] accel_lim;
   logic [TIME_W-1:0]              timeout_lim;
   logic [DT_W-1:0]                dt_cap;
   logic [NUM_AXES-1:0][VEL_W-1:0] goal_v;
   logic [NUM_AXES-1:0][VEL_W-1:0] ramp_v;
   logic [TIME_W-1:0]              last_tick;
   logic [TIME_W-1:0]              cmd_stamp;

   setpoint_type setpoint_queue [$];
   string        axis_name [NUM_AXES] = '{"x", "y", "yaw"};

   int error_count   = 0;
   int cycle_count   = 0;
   int results_seen  = 0;
   int n_commands    = 0;
   int n_ticks       = 0;
   int n_stale       = 0;
   int n_reg_writes  = 0;

   localparam logic [VEL_W-1:0] Z = 32'h0;

   // Directed table: reset limits, field extremes, timeout edge, wrapping time.
   stim_row_type stim_rows [DIRECTED_ROWS] = '{
      '{ACT_TICK,    32'd0,        {Z, Z, Z}, 1'b1,
         '{{Z, Z, Z}, {Z, Z, Z}, 1'b0}},
      '{ACT_COMMAND, 32'd10,       {32'h0, 32'h80000000, 32'h7FFFFFFF}, 1'b1,
         '{{Z, Z, Z}, {32'h0, 32'hFFFF0000, 32'h00010000}, 1'b0}},
      '{ACT_TICK,    32'd10010,    {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'd20010,    {32'hDEADBEEF, 32'h12345678, 32'hFFFFFFFF}, 1'b0, '0},
      '{ACT_TICK,    32'd20010,    {Z, Z, Z}, 1'b0, '0},
      '{ACT_COMMAND, 32'd20010,    {32'h00012345, 32'hFFFF8000, 32'h00008000}, 1'b0, '0},
      '{ACT_TICK,    32'd120010,   {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'd120011,   {Z, Z, Z}, 1'b1,
         '{{Z, Z, Z}, {32'h00010000, 32'hFFFF8000, 32'h00008000}, 1'b1}},
      '{ACT_TICK,    32'd120020,   {Z, Z, Z}, 1'b1,
         '{{Z, Z, Z}, {32'h00010000, 32'hFFFF8000, 32'h00008000}, 1'b1}},
      '{ACT_COMMAND, 32'hFFFFFFF0, {32'h80000000, 32'h00000001, 32'hFFFFFFFF}, 1'b1,
         '{{Z, Z, Z}, {32'hFFFF0000, 32'h00000001, 32'hFFFFFFFF}, 1'b0}},
      '{ACT_TICK,    32'h00000010, {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'h00000005, {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'hFFFFFFE0, {Z, Z, Z}, 1'b1,
         '{{Z, Z, Z}, {32'hFFFF0000, 32'h00000001, 32'hFFFFFFFF}, 1'b1}},
      '{ACT_COMMAND, 32'hFFFFFFFF, {32'hFFFF0001, 32'h7FFFFFFF, 32'h0000FFFF}, 1'b1,
         '{{Z, Z, Z}, {32'hFFFF0001, 32'h00010000, 32'h0000FFFF}, 1'b0}},
      '{ACT_TICK,    32'h0000270F, {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'h00004E1F, {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'h00007530, {Z, Z, Z}, 1'b0, '0},
      '{ACT_TICK,    32'h00009C40, {Z, Z, Z}, 1'b0, '0}
   };

   // Applies one item to the mirrored state and returns the response it gives.
   function automatic setpoint_type next_setpoint(input req_item_type it);
      setpoint_type res;
      logic [31:0]  dt;
      logic [31:0]  age;
      longint       lim;
      longint       v;
      longint       stepv;
      longint       diff;
      res.timed_out = 1'b0;
      if (it.action == ACT_COMMAND) begin
         // Clamp each target to plus or minus its velocity limit.
         for (int i = 0; i < NUM_AXES; i++) begin
            lim = longint'(vel_lim[i]);
            v   = longint'($signed(it.target[i]));
            if (v < -lim) begin
               v = -lim;
            end else if (v > lim) begin
               v = lim;
            end
            goal_v[i] = v[31:0];
         end
         cmd_stamp = it.time_us;
      end else begin
         dt = it.time_us - last_tick;
         if (dt > 32'(dt_cap)) begin
            dt = 32'(dt_cap);
         end
         age = it.time_us - cmd_stamp;
         if (age > timeout_lim) begin
            res.timed_out = 1'b1;
            ramp_v        = '0;
         end else begin
            // Move each ramp toward its goal by no more than the allowed step.
            for (int i = 0; i < NUM_AXES; i++) begin
               stepv = longint'((64'(accel_lim[i]) * 64'(dt)) / USEC_PER_SEC);
               diff  = longint'($signed(goal_v[i])) - longint'($signed(ramp_v[i]));
               if (diff > stepv) begin
                  diff = stepv;
               end else if (diff < -stepv) begin
                  diff = -stepv;
               end
               ramp_v[i] = ramp_v[i] + diff[31:0];
            end
         end
         last_tick = it.time_us;
      end
      res.ramp = ramp_v;
      res.goal = goal_v;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h (response %0d)",
               $realtime, what, got, want, results_seen);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Drives one item, waits for its transfer and records what it should give.
   task automatic send_item(input req_item_type it, input bit typed,
                            input setpoint_type want);
      setpoint_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {it.target, it.time_us};
      do @(posedge clock); while (!req_tready);
      predicted = next_setpoint(it);
      setpoint_queue = {setpoint_queue, (typed ? want : predicted)};
      if (it.action == ACT_COMMAND) begin
         n_commands++;
      end else begin
         n_ticks++;
      end
      if (predicted.timed_out) begin
         n_stale++;
      end
   endtask

   // Stops sending and waits until every outstanding response has arrived.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (setpoint_queue.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx <= REG_MAX_VEL_YAW) begin
         vel_lim[idx - REG_MAX_VEL_X] = val[LIM_W-1:0];
      end else if (idx <= REG_MAX_ACCEL_YAW) begin
         accel_lim[idx - REG_MAX_ACCEL_X] = val[LIM_W-1:0];
      end else if (idx == REG_TIMEOUT) begin
         timeout_lim = val;
      end else begin
         dt_cap = val[DT_W-1:0];
      end
      n_reg_writes++;
   endtask

   // Chooses a limit setting for the phase and writes all registers.
   task automatic program_limits(input int phase);
      logic [CSR_DATA_W-1:0] words [NUM_REGS];
      if (phase == 1) begin
         foreach (words[i]) words[i] = 32'hFFFFFFFF;
      end else if (phase == 2) begin
         foreach (words[i]) words[i] = 32'h0;
      end else begin
         for (int a = 0; a < NUM_AXES; a++) begin
            case ($urandom_range(0, 7))
               0:       words[REG_MAX_VEL_X + a] = 32'h0;
               1:       words[REG_MAX_VEL_X + a] = 32'h7FFFFFFF;
               2:       words[REG_MAX_VEL_X + a] = $urandom;
               default: words[REG_MAX_VEL_X + a] = $urandom_range(0, 32'h30000);
            endcase
            case ($urandom_range(0, 7))
               0:       words[REG_MAX_ACCEL_X + a] = 32'h0;
               1:       words[REG_MAX_ACCEL_X + a] = 32'h7FFFFFFF;
               2:       words[REG_MAX_ACCEL_X + a] = $urandom;
               default: words[REG_MAX_ACCEL_X + a] = $urandom_range(0, 32'h2000000);
            endcase
         end
         case ($urandom_range(0, 7))
            0:       words[REG_TIMEOUT] = 32'h0;
            1:       words[REG_TIMEOUT] = 32'hFFFFFFFF;
            2:       words[REG_TIMEOUT] = $urandom;
            default: words[REG_TIMEOUT] = $urandom_range(1000, 300000);
         endcase
         case ($urandom_range(0, 7))
            0:       words[REG_MAX_DT] = 32'h0;
            1:       words[REG_MAX_DT] = 32'h000FFFFF;
            2:       words[REG_MAX_DT] = $urandom;
            default: words[REG_MAX_DT] = $urandom_range(0, 1100000);
         endcase
      end
      for (int i = 0; i < NUM_REGS; i++) begin
         write_reg(CSR_IDX_W'(i), words[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Receiver: switches between steady, light, heavy and long-stall patterns.
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(50, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            if (stall_left != 0) begin
               rsp_tready <= 1'b0;
               stall_left <= stall_left - 1;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) begin
                  stall_left <= $urandom_range(5, 40);
               end
            end
         end
      endcase
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin : check_responses
      setpoint_type got;
      setpoint_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ramp      = rsp_tdata[NUM_AXES*VEL_W-1:0];
         got.goal      = rsp_tdata[RSP_DATA_W-1:NUM_AXES*VEL_W];
         got.timed_out = rsp_tuser;
         if (setpoint_queue.size() == 0) begin
            report_mismatch("response with none expected", got.ramp[0], 32'h0);
         end else begin
            want = setpoint_queue.pop_front();
            for (int i = 0; i < NUM_AXES; i++) begin
               check_field({"ramp_", axis_name[i]}, got.ramp[i], want.ramp[i]);
               check_field({"clamped_", axis_name[i]}, got.goal[i], want.goal[i]);
            end
            check_field("timed_out", 32'(got.timed_out), 32'(want.timed_out));
         end
         results_seen++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, setpoint_queue.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus: directed table, then random phases under changing limits.
   initial begin
      req_item_type it;
      logic [TIME_W-1:0] clock_us;
      int   burst_left;
      bit   idle_on;

      vel_lim     = {NUM_AXES{MAX_VEL_RESET}};
      accel_lim   = {NUM_AXES{MAX_ACCEL_RESET}};
      timeout_lim = TIMEOUT_RESET;
      dt_cap      = MAX_DT_RESET;
      goal_v      = '0;
      ramp_v      = '0;
      last_tick   = '0;
      cmd_stamp   = '0;
      burst_left  = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         it.action  = stim_rows[r].act;
         it.time_us = stim_rows[r].t;
         it.target  = stim_rows[r].target;
         send_item(it, stim_rows[r].typed, stim_rows[r].want);
      end
      clock_us = stim_rows[DIRECTED_ROWS-1].t;

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         wait_for_responses();
         program_limits(phase);
         // Two phases run back to back with no gaps from the sender.
         idle_on = (phase != 1) && (phase != 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Midway through one phase, let the pipeline empty completely.
            if (phase == 5 && n == PHASE_ITEMS / 2) begin
               wait_for_responses();
            end
            if (idle_on) begin
               if (burst_left == 0) begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
                  burst_left = $urandom_range(1, 16);
               end
               burst_left--;
            end

            it.action = ($urandom_range(0, 3) == 0) ? ACT_COMMAND : ACT_TICK;
            // Time mostly moves forward in control-rate steps, with jumps,
            // reversals and ticks placed on the timeout boundary.
            case ($urandom_range(0, 19))
               0:       clock_us = $urandom;
               1:       clock_us = clock_us - $urandom_range(1, 200000);
               2:       clock_us = clock_us + $urandom_range(1000000, 1100000);
               3:       clock_us = cmd_stamp + timeout_lim + $urandom_range(0, 1);
               4, 5:    clock_us = clock_us;
               default: clock_us = clock_us + $urandom_range(1, 12000);
            endcase
            it.time_us = clock_us;
            for (int a = 0; a < NUM_AXES; a++) begin
               case ($urandom_range(0, 9))
                  0:          it.target[a] = 32'h7FFFFFFF;
                  1:          it.target[a] = 32'h80000000;
                  2, 3, 4, 5: it.target[a] = $urandom;
                  default:    it.target[a] = $urandom_range(0, 32'h60000) - 32'h30000;
               endcase
            end
            send_item(it, 1'b0, '0);
         end
      end

      wait_for_responses();
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Covered %0d commands and %0d control ticks, %0d of them on a stale command.",
               n_commands, n_ticks, n_stale);
      $display("Limits rewritten %0d times over %0d settings; %0d responses compared.",
               n_reg_writes, NUM_PHASES, results_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
